/* rtl/imm_pkg.sv */
// Shared types and constants for the integer matrix multiply block.
package imm_pkg;

  localparam int WORD_W    = 32;
  localparam int OP_W      = 2;
  localparam int IDX_W     = 4;
  localparam int DIM_W     = 5;
  localparam int DIM_RESET = 16;

  typedef enum logic [OP_W-1:0] {
    OP_WR_A  = 2'd0,
    OP_WR_B  = 2'd1,
    OP_QUERY = 2'd2
  } imm_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } imm_state_t;

  // Sequencer commands to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic step;
  } imm_mac_ctl_t;

endpackage

/* rtl/imm_if.sv */
// Valid/ready channel interfaces for the input and result words.
interface imm_in_if;
  import imm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [IDX_W-1:0]         row;
  logic [IDX_W-1:0]         col;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output op, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input op, input row, input col, input value,
                  output ready);
endinterface

interface imm_out_if;
  import imm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] product;

  modport source (output valid, output product, input ready);
  modport sink   (input valid, input product, output ready);
endinterface

/* rtl/imm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module imm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

/* rtl/imm_mac.sv */
// Pipelined 32-bit multiply-accumulate unit, wrapping modulo 2^32.
module imm_mac (
  input  logic                         clk,
  input  logic                         rst_n,
  input  imm_pkg::imm_mac_ctl_t        ctl,
  input  logic [imm_pkg::WORD_W-1:0]   a,
  input  logic [imm_pkg::WORD_W-1:0]   b,
  output logic [imm_pkg::WORD_W-1:0]   acc,
  output logic                         busy
);
  import imm_pkg::*;

  logic [WORD_W-1:0] prod_r;
  logic              prod_v_r;
  logic [WORD_W-1:0] acc_r;

  // Product stage: keep the low word of a times b
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      prod_r <= a * b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else if (ctl.clear) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctl.step;
    end
  end

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + prod_r;
    end
  end

  assign acc  = acc_r;
  assign busy = prod_v_r;

endmodule

/* rtl/integer_matrix_multiply_top.sv */
// Integer matrix multiply: two stored square matrices and one product element per query.
//
// Input channel in_ch carries words {op, row, col, value}. A write to A or B
// (op 0 or 1) stores one element; rows or columns at or above
// MAX_DIM are dropped. A query (op 2) returns C[row][col], the 32-bit wrapped
// dot product of row 'row' of A with column 'col' of B over the active size n.
// Unused op codes are taken and dropped.
// cfg_we/cfg_data write the dimension register n (reset 16, saturates at
// MAX_DIM); write it only while the block is idle.
// A query walks n multiply-accumulate steps through the single shared 32x32
// multiplier, one step per cycle, reading one word of A and one of B per cycle
// from two RAMs. After the last step the sum is loaded into an output register
// for out_ch; a query out of range or with n zero runs no steps and returns zero.
// in_ch.ready is low while a query is in progress, so queries run one at a time.
// The result sits in an output register: while the receiver stalls, writes are
// still accepted, and a following query finishes its steps and then waits for
// the register to drain.
// Reset clears the sequencer and the output valid and sets n to 16; the matrix
// RAMs are not cleared and must be written before they are queried.
module integer_matrix_multiply_top #(
  parameter int MAX_DIM = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  imm_in_if.sink                      in_ch,
  imm_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [imm_pkg::DIM_W-1:0]   cfg_data
);
  import imm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  imm_state_t        state_r, state_nxt;
  logic [DIM_W-1:0]  cfg_dim_r;
  logic [DIM_W-1:0]  n_eff;
  logic [IDX_W-1:0]  qrow_r;
  logic [IDX_W-1:0]  qcol_r;
  logic [DIM_W-1:0]  qlen_r;
  logic [DIM_W-1:0]  k_r;
  logic              rd_v_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_product_r;

  logic              in_fire;
  logic              qry_go;
  logic              in_range;
  logic              wr_ok;
  logic              issue;
  logic              steps_done;
  logic              out_free;
  logic              out_load;
  imm_mac_ctl_t      mac_ctl;
  logic [WORD_W-1:0] mac_acc;
  logic              mac_busy;

  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr_a;
  logic [ADDR_W-1:0] raddr_b;
  logic [WORD_W-1:0] rdata_a;
  logic [WORD_W-1:0] rdata_b;

  // Active size: saturate the dimension register at MAX_DIM
  always_comb begin
    if (int'(cfg_dim_r) > MAX_DIM) begin
      n_eff = DIM_W'(MAX_DIM);
    end else begin
      n_eff = cfg_dim_r;
    end
  end

  // Input is ready exactly in the idle state
  assign in_fire  = in_ch.valid && (state_r == ST_IDLE);
  assign qry_go   = in_fire && (in_ch.op == OP_QUERY);
  assign in_range = ({1'b0, in_ch.row} < n_eff) && ({1'b0, in_ch.col} < n_eff);
  assign wr_ok    = (int'(in_ch.row) < MAX_DIM) && (int'(in_ch.col) < MAX_DIM);

  // Element addresses, row-major
  assign waddr   = ADDR_W'(int'(in_ch.row) * MAX_DIM + int'(in_ch.col));
  assign raddr_a = ADDR_W'(int'(qrow_r) * MAX_DIM + int'(k_r));
  assign raddr_b = ADDR_W'(int'(k_r) * MAX_DIM + int'(qcol_r));

  assign issue      = (state_r == ST_RUN) && (k_r < qlen_r);
  assign steps_done = (k_r == qlen_r) && !rd_v_r && !mac_busy;
  assign out_free   = !out_valid_r || out_ch.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (qry_go) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (steps_done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ch.ready   = 1'b0;
    mac_ctl.clear = 1'b0;
    mac_ctl.step  = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready   = 1'b1;
        mac_ctl.clear = qry_go;
      end
      ST_RUN: begin
        mac_ctl.step = rd_v_r;
      end
      ST_HOLD: begin
        out_load = out_free;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_dim_r   <= DIM_W'(DIM_RESET);
      k_r         <= '0;
      qlen_r      <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cfg_dim_r <= cfg_data;
      end
      if (qry_go) begin
        k_r    <= '0;
        qlen_r <= in_range ? n_eff : '0;
      end else if (issue) begin
        k_r <= k_r + 1'b1;
      end
      rd_v_r <= issue;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the query coordinates and the result word
  always_ff @(posedge clk) begin
    if (qry_go) begin
      qrow_r <= in_ch.row;
      qcol_r <= in_ch.col;
    end
    if (out_load) begin
      out_product_r <= mac_acc;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.product = signed'(out_product_r);

  imm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH),
    .AW    (ADDR_W)
  ) u_ram_a (
    .clk     (clk),
    .we      (in_fire && (in_ch.op == OP_WR_A) && wr_ok),
    .waddr   (waddr),
    .wdata   (WORD_W'(in_ch.value)),
    .raddr   (raddr_a),
    .rdata_r (rdata_a)
  );

  imm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH),
    .AW    (ADDR_W)
  ) u_ram_b (
    .clk     (clk),
    .we      (in_fire && (in_ch.op == OP_WR_B) && wr_ok),
    .waddr   (waddr),
    .wdata   (WORD_W'(in_ch.value)),
    .raddr   (raddr_b),
    .rdata_r (rdata_b)
  );

  imm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a     (rdata_a),
    .b     (rdata_b),
    .acc   (mac_acc),
    .busy  (mac_busy)
  );

endmodule
